### rtl/tkcs_pkg.sv
`default_nettype none

package tkcs_pkg;

    localparam int KEY_W      = 48;
    localparam int COUNT_W    = 32;
    localparam int HEAP_DEPTH = 1024;
    localparam int HEAP_AW    = $clog2(HEAP_DEPTH);
    localparam int SIZE_W     = HEAP_AW + 1;
    localparam int ENTRY_W    = COUNT_W + KEY_W;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [SIZE_W-1:0] HEAP_FULL = SIZE_W'(HEAP_DEPTH);
    localparam logic [SIZE_W-1:0] CAP_RESET = SIZE_W'(1024);

    // request opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_POP   = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic [1:0]         op;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key_out;
        logic [COUNT_W-1:0] count_out;
        logic               valid_res;
        logic               last;
    } out_item_t;

    // count above key: a plain unsigned compare orders entries by count, then key
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [KEY_W-1:0]   key;
    } heap_entry_t;

    typedef struct packed {
        logic        ins;
        logic        pop;
        heap_entry_t entry;
    } heap_cmd_t;

    typedef struct packed {
        logic               we;
        logic [HEAP_AW-1:0] waddr;
        heap_entry_t        wdata;
        logic [HEAP_AW-1:0] raddr_a;
        logic [HEAP_AW-1:0] raddr_b;
    } ram_req_t;

endpackage

`default_nettype wire

### rtl/tkcs_heap_ram.sv
`default_nettype none

module tkcs_heap_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 80
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

### rtl/tkcs_run_acc.sv
`default_nettype none

module tkcs_run_acc (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire tkcs_pkg::in_item_t  item,
    output tkcs_pkg::heap_cmd_t      cmd
);

    logic [tkcs_pkg::KEY_W-1:0]   pend_key_reg, pend_key_next;
    logic [tkcs_pkg::COUNT_W-1:0] pend_count_reg, pend_count_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic                         is_add, is_close, hit;
    logic [tkcs_pkg::COUNT_W:0]   sum;

    assign is_add   = (item.op == tkcs_pkg::OP_ADD);
    assign is_close = (item.op == tkcs_pkg::OP_CLOSE);
    assign hit      = pend_valid_reg && (pend_key_reg == item.key);
    assign sum      = {1'b0, pend_count_reg} + {1'b0, item.count};

    // flush the pending run on a key change or a close
    always_comb
    begin
        cmd.ins         = take && pend_valid_reg && ((is_add && !hit) || is_close);
        cmd.pop         = take && (item.op == tkcs_pkg::OP_POP);
        cmd.entry.count = pend_count_reg;
        cmd.entry.key   = pend_key_reg;
    end

    always_comb
    begin
        pend_key_next   = pend_key_reg;
        pend_count_next = pend_count_reg;
        pend_valid_next = pend_valid_reg;
        if (take && is_add)
        begin
            if (hit)
            begin
                pend_count_next = sum[tkcs_pkg::COUNT_W] ? '1 : sum[tkcs_pkg::COUNT_W-1:0];
            end
            else
            begin
                pend_key_next   = item.key;
                pend_count_next = item.count;
                pend_valid_next = 1'b1;
            end
        end
        else if (take && is_close)
        begin
            pend_key_next   = '0;
            pend_count_next = '0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_key_reg   <= '0;
            pend_count_reg <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_key_reg   <= pend_key_next;
            pend_count_reg <= pend_count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

`default_nettype wire

### rtl/tkcs_heap_ctrl.sv
`default_nettype none

module tkcs_heap_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic [tkcs_pkg::SIZE_W-1:0]       cap,
    input  wire tkcs_pkg::heap_cmd_t               cmd,
    input  wire logic                              room,
    input  wire tkcs_pkg::heap_entry_t             rd_a,
    input  wire tkcs_pkg::heap_entry_t             rd_b,
    output tkcs_pkg::ram_req_t                     ram,
    output logic                                   busy,
    output logic                                   push,
    output tkcs_pkg::out_item_t                    res
);

    localparam int AW = tkcs_pkg::HEAP_AW;
    localparam int SW = tkcs_pkg::SIZE_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SUP    = 3'd1;
    localparam logic [2:0] ST_FIN    = 3'd2;
    localparam logic [2:0] ST_REP    = 3'd3;
    localparam logic [2:0] ST_SDN    = 3'd4;
    localparam logic [2:0] ST_POPRD  = 3'd5;
    localparam logic [2:0] ST_POPOUT = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [SW-1:0]         size_reg, size_next;
    logic [AW-1:0]         hole_reg, hole_next;
    tkcs_pkg::heap_entry_t ent_reg, ent_next;
    tkcs_pkg::out_item_t   res_reg, res_next;

    logic [SW-1:0]   cap_eff;
    logic [SW-1:0]   size_dec;
    logic [AW-1:0]   last_idx, size_par, hole_par, par_par, pick_idx;
    logic [SW:0]     l_idx, r_idx, size_x;
    logic            l_ok, r_ok, l_lt_e, pick_l, pick_r;

    always_comb
    begin
        if (cap == '0)
            cap_eff = SW'(1);
        else if (cap > tkcs_pkg::HEAP_FULL)
            cap_eff = tkcs_pkg::HEAP_FULL;
        else
            cap_eff = cap;
    end

    assign size_dec = size_reg - SW'(1);
    assign last_idx = size_dec[AW-1:0];
    assign size_par = last_idx >> 1;
    assign hole_par = (hole_reg - AW'(1)) >> 1;
    assign par_par  = (hole_par - AW'(1)) >> 1;

    // children of the hole, one bit wider than the size to catch the edge
    assign l_idx  = {1'b0, hole_reg, 1'b1};
    assign r_idx  = l_idx + (SW+1)'(1);
    assign size_x = {1'b0, size_reg};
    assign l_ok   = l_idx < size_x;
    assign r_ok   = r_idx < size_x;

    // smallest of hole entry, left and right; strict compares keep the hole on ties
    always_comb
    begin
        l_lt_e = l_ok && (rd_a < ent_reg);
        if (l_lt_e)
            pick_r = r_ok && (rd_b < rd_a);
        else
            pick_r = r_ok && (rd_b < ent_reg);
        pick_l   = l_lt_e && !pick_r;
        pick_idx = pick_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
    end

    always_comb
    begin
        state_next  = state_reg;
        size_next   = size_reg;
        hole_next   = hole_reg;
        ent_next    = ent_reg;
        res_next    = res_reg;
        push        = 1'b0;
        ram.we      = 1'b0;
        ram.waddr   = hole_reg;
        ram.wdata   = ent_reg;
        ram.raddr_a = '0;
        ram.raddr_b = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.ins)
                begin
                    ent_next = cmd.entry;
                    if (size_reg < cap_eff)
                    begin
                        if (size_reg == '0)
                        begin
                            ram.we    = 1'b1;
                            ram.waddr = '0;
                            ram.wdata = cmd.entry;
                            size_next = SW'(1);
                        end
                        else
                        begin
                            hole_next   = size_reg[AW-1:0];
                            ram.raddr_a = size_par;
                            size_next   = size_reg + SW'(1);
                            state_next  = ST_SUP;
                        end
                    end
                    else
                    begin
                        ram.raddr_a = '0;
                        state_next  = ST_REP;
                    end
                end
                else if (cmd.pop)
                begin
                    if (size_reg == '0)
                    begin
                        res_next   = '0;
                        state_next = ST_POPOUT;
                    end
                    else
                    begin
                        ram.raddr_a = '0;
                        ram.raddr_b = last_idx;
                        state_next  = ST_POPRD;
                    end
                end
            end

            ST_SUP:
            begin
                ram.we = 1'b1;
                if (ent_reg < rd_a)
                begin
                    // move the parent down into the hole and climb
                    ram.wdata   = rd_a;
                    hole_next   = hole_par;
                    ram.raddr_a = par_par;
                    if (hole_par == '0)
                        state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_FIN:
            begin
                ram.we     = 1'b1;
                state_next = ST_IDLE;
            end

            ST_REP:
            begin
                if (ent_reg.count > rd_a.count)
                begin
                    hole_next   = '0;
                    ram.raddr_a = AW'(1);
                    ram.raddr_b = AW'(2);
                    state_next  = ST_SDN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_SDN:
            begin
                ram.we = 1'b1;
                if (pick_l || pick_r)
                begin
                    ram.wdata   = pick_r ? rd_b : rd_a;
                    hole_next   = pick_idx;
                    ram.raddr_a = {pick_idx[AW-2:0], 1'b1};
                    ram.raddr_b = {pick_idx[AW-2:0], 1'b1} + AW'(1);
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_POPRD:
            begin
                res_next.key_out   = rd_a.key;
                res_next.count_out = rd_a.count;
                res_next.valid_res = 1'b1;
                res_next.last      = (size_dec == '0);
                ent_next           = rd_b;
                size_next          = size_dec;
                state_next         = ST_POPOUT;
            end

            ST_POPOUT:
            begin
                if (room)
                begin
                    push = 1'b1;
                    if (size_reg != '0)
                    begin
                        hole_next   = '0;
                        ram.raddr_a = AW'(1);
                        ram.raddr_b = AW'(2);
                        state_next  = ST_SDN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign res  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            size_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hole_reg <= hole_next;
        ent_reg  <= ent_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

### rtl/top_k_count_selector.sv
// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+---------------------------------
// req     | in        | req_valid/req_stall  | in_item_t  (op, key, count)
// res     | out       | res_valid/res_stall  | out_item_t (key_out, count_out,
//         |           |                      |             valid_res, last)
// apb     | in/out    | psel/penable/pready  | capacity_in_use at byte address 0
//
// An add that needs no flush, or a flush into an empty heap, leaves the engine idle. Other
// inserts climb the heap one level at a time; a replacement descends one level at a time (or
// is rejected at the root); a pop descends likewise, unless the heap was empty or it empties.
// Reset clears size and pending run, not the RAM. A stalled result waits in the output
// register while further transfers are taken; the next pop then holds req_stall high until
// that register drains.

`default_nettype none

module top_k_count_selector (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          req_valid,
    output logic                               req_stall,
    input  wire tkcs_pkg::in_item_t            req_data,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output tkcs_pkg::out_item_t                res_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tkcs_pkg::APB_AW-1:0]   paddr,
    input  wire logic [tkcs_pkg::APB_DW-1:0]   pwdata,
    output logic      [tkcs_pkg::APB_DW-1:0]   prdata,
    output logic                               pready
);

    logic [tkcs_pkg::SIZE_W-1:0] cap_reg, cap_next;
    logic                        res_valid_reg, res_valid_next;
    tkcs_pkg::out_item_t         res_data_reg, res_data_next;

    logic                        take, busy, push, room;
    tkcs_pkg::heap_cmd_t         cmd;
    tkcs_pkg::ram_req_t          ram;
    tkcs_pkg::out_item_t         ctrl_res;
    tkcs_pkg::heap_entry_t       rd_a, rd_b;

    // Configuration: one register, to be written only while the engine is idle; the block does not enforce this.
    assign pready = 1'b1;

    always_comb
    begin
        cap_next = cap_reg;
        if (psel && penable && pwrite && (paddr[2] == tkcs_pkg::REG_CAPACITY))
            cap_next = pwdata[tkcs_pkg::SIZE_W-1:0];
    end

    always_comb
    begin
        if (paddr[2] == tkcs_pkg::REG_CAPACITY)
            prdata = {{(tkcs_pkg::APB_DW-tkcs_pkg::SIZE_W){1'b0}}, cap_reg};
        else
            prdata = '0;
    end

    // Take a request whenever the heap engine is idle; the engine only waits on the
    // output register when a pop result finds it still full.
    assign req_stall = busy;
    assign take      = req_valid && !busy;

    tkcs_run_acc u_run_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (req_data),
        .cmd   (cmd)
    );

    tkcs_heap_ctrl u_heap_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .cap   (cap_reg),
        .cmd   (cmd),
        .room  (room),
        .rd_a  (rd_a),
        .rd_b  (rd_b),
        .ram   (ram),
        .busy  (busy),
        .push  (push),
        .res   (ctrl_res)
    );

    tkcs_heap_ram #(
        .DEPTH (tkcs_pkg::HEAP_DEPTH),
        .WIDTH (tkcs_pkg::ENTRY_W)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram.we),
        .waddr   (ram.waddr),
        .wdata   (ram.wdata),
        .raddr_a (ram.raddr_a),
        .raddr_b (ram.raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // Output register: load when empty or draining this cycle, otherwise hold.
    assign room = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        if (push)
        begin
            res_valid_next = 1'b1;
            res_data_next  = ctrl_res;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= tkcs_pkg::CAP_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

endmodule

`default_nettype wire

### rtl/tkcs_checker.sv
`default_nettype none

module tkcs_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          res_valid,
    input wire logic                          res_stall,
    input wire tkcs_pkg::out_item_t           res_data,
    input wire logic [tkcs_pkg::APB_DW-1:0]   prdata,
    input wire logic                          pready
);

    // an empty-heap pop carries all zeros
    a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.valid_res |->
            (res_data.key_out == '0) && (res_data.count_out == '0) && !res_data.last)
        else $error("empty pop result not zero");

    // only a real pop can empty the heap
    a_last_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.last |-> res_data.valid_res)
        else $error("last set without a popped entry");

    // hold a stalled result
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // capacity readback fits its field and the port never waits
    a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
        pready && (prdata[tkcs_pkg::APB_DW-1:tkcs_pkg::SIZE_W] == '0))
        else $error("bad register readback");

endmodule

bind top_k_count_selector tkcs_checker u_tkcs_checker (.*);

`default_nettype wire

### dv/tb_top_k_count_selector.sv
`timescale 1ns / 100ps

module tb_top_k_count_selector;

    // Opcode the block must ignore
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam logic [tkcs_pkg::KEY_W-1:0]   KEY_ALL  = '1;
    localparam logic [tkcs_pkg::COUNT_W-1:0] CNT_ALL  = '1;
    localparam logic [tkcs_pkg::KEY_W-1:0]   KEY_TOP  = {1'b1, {(tkcs_pkg::KEY_W-1){1'b0}}};
    localparam logic [tkcs_pkg::COUNT_W-1:0] CNT_HALF = {1'b1, {(tkcs_pkg::COUNT_W-1){1'b0}}};

    // A pop walks about ten heap levels; leave generous room past that
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int RUN_LIMIT_NS  = 5000000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 80;

    typedef struct packed {
        logic [1:0]                   op;
        logic [tkcs_pkg::KEY_W-1:0]   key;
        logic [tkcs_pkg::COUNT_W-1:0] count;
        logic                         typed;
        tkcs_pkg::out_item_t          want;
    } script_row_t;

    //------------------------------------------------------------------
    // DUT connections, every input known from time zero
    //------------------------------------------------------------------
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_stall;
    tkcs_pkg::in_item_t            req_data  = '0;
    logic                          res_valid;
    logic                          res_stall = 1'b0;
    tkcs_pkg::out_item_t           res_data;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [tkcs_pkg::APB_AW-1:0]   paddr     = '0;
    logic [tkcs_pkg::APB_DW-1:0]   pwdata    = '0;
    logic [tkcs_pkg::APB_DW-1:0]   prdata;
    logic                          pready;

    top_k_count_selector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    //------------------------------------------------------------------
    // Bench state
    //------------------------------------------------------------------
    tkcs_pkg::out_item_t pops_due [$];     // popped entries still owed by the block
    int unsigned mismatches  = 0;
    int unsigned hold_reqs   = 0;  // bumped by the sender to ask for a long result hold
    logic        quiet       = 1'b0;
    logic [tkcs_pkg::KEY_W-1:0] walk_key = '0;

    // Software copy of the heap, the pending run and the capacity register
    logic [tkcs_pkg::KEY_W-1:0]   heap_keys   [tkcs_pkg::HEAP_DEPTH];
    logic [tkcs_pkg::COUNT_W-1:0] heap_counts [tkcs_pkg::HEAP_DEPTH];
    int unsigned                  heap_fill   = 0;
    logic [tkcs_pkg::KEY_W-1:0]   run_key     = '0;
    logic [tkcs_pkg::COUNT_W-1:0] run_count   = '0;
    logic                         run_open    = 1'b0;
    logic [tkcs_pkg::SIZE_W-1:0]  cap_setting = tkcs_pkg::CAP_RESET;

    // Opening script. Pops with an obvious answer carry it inline; the rest
    // are scored by the heap copy.
    script_row_t script_rows [25] = '{
        // pop on an empty heap gives an all-zero result
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b1, '{'0, '0, 1'b0, 1'b0}},
        // close with nothing pending, then an unused opcode
        '{tkcs_pkg::OP_CLOSE, '0,        '0,       1'b0, '0},
        '{OP_SPARE,           KEY_ALL,   CNT_ALL,  1'b0, '0},
        // saturating run on key zero, then a key change to the top key
        '{tkcs_pkg::OP_ADD,   '0,        CNT_ALL,  1'b0, '0},
        '{tkcs_pkg::OP_ADD,   '0,        32'd5,    1'b0, '0},
        '{tkcs_pkg::OP_ADD,   KEY_ALL,   '0,       1'b0, '0},
        '{tkcs_pkg::OP_CLOSE, '0,        '0,       1'b0, '0},
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b1, '{KEY_ALL, '0, 1'b1, 1'b0}},
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b1, '{'0, CNT_ALL, 1'b1, 1'b1}},
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b1, '{'0, '0, 1'b0, 1'b0}},
        // equal counts, a lower key that still closes the run
        '{tkcs_pkg::OP_ADD,   48'd100,   32'd7,    1'b0, '0},
        '{tkcs_pkg::OP_ADD,   48'd101,   32'd7,    1'b0, '0},
        '{tkcs_pkg::OP_ADD,   48'd50,    32'd7,    1'b0, '0},
        '{tkcs_pkg::OP_ADD,   48'd50,    32'd0,    1'b0, '0},
        '{tkcs_pkg::OP_ADD,   48'd200,   32'd1,    1'b0, '0},
        // ties go to the smaller key; the pending run stays out of the heap
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b0, '0},
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b0, '0},
        '{tkcs_pkg::OP_CLOSE, '0,        '0,       1'b0, '0},
        '{tkcs_pkg::OP_CLOSE, '0,        '0,       1'b0, '0},
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b0, '0},
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b0, '0},
        // two halves that overflow the count
        '{tkcs_pkg::OP_ADD,   KEY_TOP,   CNT_HALF, 1'b0, '0},
        '{tkcs_pkg::OP_ADD,   KEY_TOP,   CNT_HALF, 1'b0, '0},
        '{tkcs_pkg::OP_CLOSE, '0,        '0,       1'b0, '0},
        '{tkcs_pkg::OP_POP,   '0,        '0,       1'b0, '0}
    };

    //------------------------------------------------------------------
    // Heap copy
    //------------------------------------------------------------------
    function automatic logic ranks_below(int unsigned a, int unsigned b);
        if (heap_counts[a] != heap_counts[b])
            return heap_counts[a] < heap_counts[b];
        return heap_keys[a] < heap_keys[b];
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic [tkcs_pkg::KEY_W-1:0]   k;
        logic [tkcs_pkg::COUNT_W-1:0] c;
        k = heap_keys[a];
        c = heap_counts[a];
        heap_keys[a]   = heap_keys[b];
        heap_counts[a] = heap_counts[b];
        heap_keys[b]   = k;
        heap_counts[b] = c;
    endfunction

    function automatic void sift_toward_root(int unsigned i);
        int unsigned up;
        logic        settled;
        settled = 1'b0;
        while (i > 0 && !settled)
        begin
            up = (i - 1) / 2;
            if (ranks_below(i, up))
            begin
                swap_entries(i, up);
                i = up;
            end
            else
                settled = 1'b1;
        end
    endfunction

    function automatic void sift_toward_leaves(int unsigned i);
        int unsigned l, r, m;
        logic        settled;
        settled = 1'b0;
        while (!settled)
        begin
            l = 2 * i + 1;
            r = l + 1;
            m = i;
            if (l < heap_fill && ranks_below(l, m))
                m = l;
            if (r < heap_fill && ranks_below(r, m))
                m = r;
            if (m == i)
                settled = 1'b1;
            else
            begin
                swap_entries(i, m);
                i = m;
            end
        end
    endfunction

    // Insert while below capacity, else replace the minimum on a strictly larger count
    function automatic void offer_run(logic [tkcs_pkg::KEY_W-1:0] k,
                                      logic [tkcs_pkg::COUNT_W-1:0] c);
        int unsigned room;
        room = (cap_setting == 0) ? 1 :
               (cap_setting > tkcs_pkg::HEAP_DEPTH) ? tkcs_pkg::HEAP_DEPTH : int'(cap_setting);
        if (heap_fill < room)
        begin
            heap_keys[heap_fill]   = k;
            heap_counts[heap_fill] = c;
            heap_fill++;
            sift_toward_root(heap_fill - 1);
        end
        else if (heap_fill > 0 && c > heap_counts[0])
        begin
            heap_keys[0]   = k;
            heap_counts[0] = c;
            sift_toward_leaves(0);
        end
    endfunction

    function automatic void close_run();
        if (run_open)
            offer_run(run_key, run_count);
        run_open  = 1'b0;
        run_key   = '0;
        run_count = '0;
    endfunction

    // Advance the heap copy by one accepted transfer; flag a result for pops
    function automatic void topk_apply(input tkcs_pkg::in_item_t it, output logic emits,
                                       output tkcs_pkg::out_item_t res);
        logic [tkcs_pkg::COUNT_W:0] total;
        emits = 1'b0;
        res   = '0;
        case (it.op)
            tkcs_pkg::OP_ADD:
                if (run_open && run_key == it.key)
                begin
                    total     = {1'b0, run_count} + {1'b0, it.count};
                    run_count = total[tkcs_pkg::COUNT_W] ? CNT_ALL
                                                         : total[tkcs_pkg::COUNT_W-1:0];
                end
                else
                begin
                    close_run();
                    run_key   = it.key;
                    run_count = it.count;
                    run_open  = 1'b1;
                end
            tkcs_pkg::OP_CLOSE:
                close_run();
            tkcs_pkg::OP_POP:
            begin
                emits = 1'b1;
                if (heap_fill != 0)
                begin
                    res.key_out   = heap_keys[0];
                    res.count_out = heap_counts[0];
                    res.valid_res = 1'b1;
                    heap_fill--;
                    if (heap_fill != 0)
                    begin
                        heap_keys[0]   = heap_keys[heap_fill];
                        heap_counts[0] = heap_counts[heap_fill];
                        sift_toward_leaves(0);
                    end
                    res.last = (heap_fill == 0);
                end
            end
            default: ;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Random items: mostly well-ordered runs, with some reordering noise
    //------------------------------------------------------------------
    function automatic logic [tkcs_pkg::KEY_W-1:0] rand_key();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic tkcs_pkg::in_item_t random_item();
        tkcs_pkg::in_item_t it;
        int unsigned        roll;
        it.op    = OP_SPARE;
        it.key   = rand_key();
        it.count = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return it;
        if (roll < 18)
        begin
            it.op = tkcs_pkg::OP_CLOSE;
            return it;
        end
        if (roll >= 74)
        begin
            it.op = tkcs_pkg::OP_POP;
            return it;
        end
        // Add: repeat the key, walk it forward, or jump (possibly backward)
        it.op = tkcs_pkg::OP_ADD;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            ;
        else if (roll < 82)
            walk_key = walk_key + tkcs_pkg::KEY_W'($urandom_range(1, 1000));
        else if (roll < 95)
            walk_key = walk_key + (rand_key() >> $urandom_range(1, tkcs_pkg::KEY_W - 1));
        else
            walk_key = rand_key();
        it.key = walk_key;
        // Small counts give ties, near-max counts give saturation
        roll = $urandom_range(0, 99);
        if (roll < 40)
            it.count = tkcs_pkg::COUNT_W'($urandom_range(0, 15));
        else if (roll < 70)
            it.count = tkcs_pkg::COUNT_W'($urandom_range(0, 5000));
        else if (roll < 88)
            it.count = $urandom;
        else
            it.count = CNT_ALL - tkcs_pkg::COUNT_W'($urandom_range(0, 3));
        return it;
    endfunction

    //------------------------------------------------------------------
    // Sender side
    //------------------------------------------------------------------
    // Offer one transfer and hold it until accepted; use the inline answer if given
    task automatic send_item(input tkcs_pkg::in_item_t it, input logic typed,
                             input tkcs_pkg::out_item_t want);
        logic                emits;
        tkcs_pkg::out_item_t res;
        req_data  <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        topk_apply(it, emits, res);
        if (emits)
            pops_due.push_back(typed ? want : res);
    endtask

    // Drop valid for a random burst now and then
    task automatic maybe_pause(input logic gappy);
        if (gappy && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Idle the request side until every result is back and the heap has settled
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (pops_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the edge with pready high
    task automatic write_capacity(input logic [tkcs_pkg::SIZE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {tkcs_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= tkcs_pkg::APB_DW'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        cap_setting = value;
    endtask

    // Pop the heap dry, then once more to hit the empty case
    task automatic drain_heap(input logic gappy);
        tkcs_pkg::in_item_t pop_item;
        pop_item       = '0;
        pop_item.op    = tkcs_pkg::OP_POP;
        while (heap_fill != 0)
        begin
            pop_item.key   = rand_key();
            pop_item.count = $urandom;
            send_item(pop_item, 1'b0, '0);
            maybe_pause(gappy);
        end
        send_item(pop_item, 1'b0, '0);
    endtask

    //------------------------------------------------------------------
    // Clock, reset, time limit
    //------------------------------------------------------------------
    initial
    begin
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Simulation FAILED");
        $finish;
    end

    //------------------------------------------------------------------
    // Result stall: short random bursts, long open stretches, a long hold on
    // request, and nothing once the run goes quiet
    //------------------------------------------------------------------
    initial
    begin : res_stall_drive
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned holds_served;
        logic        stalling;
        run_left     = 0;
        hold_left    = 0;
        holds_served = 0;
        stalling     = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (hold_reqs != holds_served)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (run_left > 0)
                run_left--;
            else if (quiet || stalling)
            begin
                stalling = 1'b0;
                if (!quiet)
                    run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(1, 30);
            end
            else
            begin
                stalling = 1'b1;
                run_left = $urandom_range(0, 16);
            end
            res_stall <= stalling || (hold_left > 0);
        end
    end

    //------------------------------------------------------------------
    // Result scoreboard: every transfer must match the oldest owed pop
    //------------------------------------------------------------------
    initial
    begin : result_check
        tkcs_pkg::out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
            begin
                if (pops_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result key=%h count=%h valid=%b last=%b",
                                 $realtime, res_data.key_out, res_data.count_out,
                                 res_data.valid_res, res_data.last);
                end
                else
                begin
                    want = pops_due.pop_front();
                    if (res_data.key_out   !== want.key_out   ||
                        res_data.count_out !== want.count_out ||
                        res_data.valid_res !== want.valid_res ||
                        res_data.last      !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: exp/got key %h/%h count %h/%h valid %b/%b last %b/%b",
                                     $realtime, want.key_out, res_data.key_out,
                                     want.count_out, res_data.count_out,
                                     want.valid_res, res_data.valid_res,
                                     want.last, res_data.last);
                    end
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Stimulus
    //------------------------------------------------------------------
    initial
    begin : stimulus
        tkcs_pkg::in_item_t          item;
        logic [tkcs_pkg::SIZE_W-1:0] caps   [PHASES];
        logic                        drains [PHASES];
        logic                        gappy;
        int                          p, k, spins;

        // Capacity plan: the low extreme, zero acting as one, above the depth,
        // a cut below the current fill, full depth, then random picks
        caps[0] = tkcs_pkg::SIZE_W'(1);                       drains[0] = 1'b1;
        caps[1] = '0;                                         drains[1] = 1'b1;
        caps[2] = '1;                                         drains[2] = 1'b0;
        caps[3] = tkcs_pkg::SIZE_W'(3);                       drains[3] = 1'b0;
        caps[4] = tkcs_pkg::HEAP_FULL;                        drains[4] = 1'b1;
        caps[5] = tkcs_pkg::SIZE_W'($urandom_range(2, 16));   drains[5] = 1'($urandom);
        caps[6] = tkcs_pkg::SIZE_W'($urandom_range(1, 2047)); drains[6] = 1'b1;
        caps[7] = tkcs_pkg::SIZE_W'($urandom_range(2, 8));    drains[7] = 1'b1;

        wait (rst_n === 1'b1);
        @(posedge clk);

        // Scripted opening at the reset capacity
        foreach (script_rows[i])
        begin
            item.op    = script_rows[i].op;
            item.key   = script_rows[i].key;
            item.count = script_rows[i].count;
            send_item(item, script_rows[i].typed, script_rows[i].want);
            maybe_pause(1'b1);
        end

        for (p = 0; p < PHASES; p++)
        begin
            // Reconfigure only with nothing in flight
            wait_drained();
            write_capacity(caps[p]);
            if ($urandom_range(0, 1) == 0)
                walk_key = tkcs_pkg::KEY_W'($urandom_range(0, 1000));
            // The last phase runs with no idling on either side
            if (p == PHASES - 1)
                quiet <= 1'b1;
            gappy = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);

            for (k = 0; k < PHASE_ITEMS; k++)
            begin
                // Hold results off for a long stretch while requests keep coming,
                // then pause the sender until everything owed has come back
                if (p == 4 && k == 10)
                    hold_reqs <= hold_reqs + 1;
                if (p == 4 && k == 50)
                    wait_drained();
                item = random_item();
                send_item(item, 1'b0, '0);
                maybe_pause(gappy);
            end
            if (drains[p])
                drain_heap(gappy);
        end

        // Let the last results arrive, bounded, then settle
        req_valid <= 1'b0;
        for (spins = 0; spins < 20000 && pops_due.size() != 0; spins++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pops_due.size() != 0)
        begin
            $display("%0d expected results never arrived", pops_due.size());
            mismatches += pops_due.size();
        end

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
